// File: sv/cpo_pkg.sv
package cpo_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_W      = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int PT_W         = 2 * COORD_W;
  localparam int AXIS_W       = COORD_W + 1;
  localparam int PROD_W       = AXIS_W + COORD_W;
  localparam int DOT_W        = PROD_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_EDGE_C,
    ST_PROJ,
    ST_EVAL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic hit0;
    logic hit1;
  } proj_ctl_t;

endpackage

// File: sv/cpo_proj.sv
module cpo_proj (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cpo_pkg::proj_ctl_t                   ctl,
  input  logic signed [cpo_pkg::AXIS_W-1:0]    axis_x,
  input  logic signed [cpo_pkg::AXIS_W-1:0]    axis_y,
  input  logic        [cpo_pkg::PT_W-1:0]      pt0,
  input  logic        [cpo_pkg::PT_W-1:0]      pt1,
  output logic                                 pending,
  output logic                                 separates
);

  localparam int CW = cpo_pkg::COORD_W;

  logic signed [CW-1:0] x0, y0, x1, y1;
  logic signed [cpo_pkg::PROD_W-1:0] p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [cpo_pkg::DOT_W-1:0]  d0, d1;
  logic signed [cpo_pkg::DOT_W-1:0]  min0_r, max0_r, min1_r, max1_r;
  logic mv_r, mh0_r, mh1_r, seen0_r, seen1_r;

  assign x0 = $signed(pt0[2*CW-1:CW]);
  assign y0 = $signed(pt0[CW-1:0]);
  assign x1 = $signed(pt1[2*CW-1:CW]);
  assign y1 = $signed(pt1[CW-1:0]);

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      p0x_r <= axis_x * x0;
      p0y_r <= axis_y * y0;
      p1x_r <= axis_x * x1;
      p1y_r <= axis_y * y1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r  <= 1'b0;
      mh0_r <= 1'b0;
      mh1_r <= 1'b0;
    end else begin
      mv_r  <= ctl.valid;
      mh0_r <= ctl.hit0;
      mh1_r <= ctl.hit1;
    end
  end

  assign d0 = cpo_pkg::DOT_W'(p0x_r) + cpo_pkg::DOT_W'(p0y_r);
  assign d1 = cpo_pkg::DOT_W'(p1x_r) + cpo_pkg::DOT_W'(p1y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen0_r <= 1'b0;
      seen1_r <= 1'b0;
    end else if (ctl.clear) begin
      seen0_r <= 1'b0;
      seen1_r <= 1'b0;
    end else if (mv_r) begin
      if (mh0_r) seen0_r <= 1'b1;
      if (mh1_r) seen1_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      min0_r <= '0;
      max0_r <= '0;
      min1_r <= '0;
      max1_r <= '0;
    end else if (mv_r) begin
      if (mh0_r) begin
        if (!seen0_r || d0 < min0_r) min0_r <= d0;
        if (!seen0_r || max0_r < d0) max0_r <= d0;
      end
      if (mh1_r) begin
        if (!seen1_r || d1 < min1_r) min1_r <= d1;
        if (!seen1_r || max1_r < d1) max1_r <= d1;
      end
    end
  end

  assign pending   = mv_r;
  assign separates = (min0_r < min1_r) ? (max0_r < min1_r) : (max1_r < min0_r);

endmodule

// File: sv/convex_polygon_overlap_test.sv
// Overlap test for two convex polygons by the separating axis theorem.
// Input channel: one vertex per transaction (in_mode selects the polygon,
// in_vertex_x/y plus in_offset_x/y is saturated to 16 bits and stored).
// Each polygon holds up to 16 vertices; extra vertices are dropped and
// flagged. A transaction with in_last set stores its vertex and starts the
// test, or reports an overflow without one; only such a transaction produces
// one result transaction on the output channel (out_intersects, out_status).
// Vertices are taken one per cycle while no test runs and no result waits.
// A test walks the edges of both polygons until an axis separates them;
// each edge takes two reads of the vertex memory for the edge and one read
// per vertex of both memories in parallel for the projection, through a
// two-stage multiply and min/max pipeline. An overflow result skips the
// test and goes from the last vertex straight to the result state.
// The input is stalled while a test runs or its result waits.
// A stalled result is held in the output register while new vertices are
// still taken; a second result waits, with the input stalled, until the
// output register is free.
// Reset clears the vertex counts, the overflow flag and the output valid.
module convex_polygon_overlap_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic signed [15:0]  in_vertex_x,
  input  logic signed [15:0]  in_vertex_y,
  input  logic signed [15:0]  in_offset_x,
  input  logic signed [15:0]  in_offset_y,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_intersects,
  output logic                out_status
);

  localparam int CW    = cpo_pkg::COORD_W;
  localparam int IDX_W = cpo_pkg::IDX_W;
  localparam int CNT_W = cpo_pkg::CNT_W;
  localparam int AW    = cpo_pkg::AXIS_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(cpo_pkg::MAX_VERTICES);

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return s[CW-1:0];
  endfunction

  logic [cpo_pkg::PT_W-1:0] mem0 [cpo_pkg::MAX_VERTICES];
  logic [cpo_pkg::PT_W-1:0] mem1 [cpo_pkg::MAX_VERTICES];
  logic [cpo_pkg::PT_W-1:0] rd0_r, rd1_r, wdata, vi_r, vi_nxt, vj;

  cpo_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [CNT_W-1:0] e_r, e_nxt, k_r, k_nxt, n_cur, m_cnt, e_inc;
  logic             ovf_r, ovf_nxt, poly_r, poly_nxt;
  logic             res_int_r, res_int_nxt, res_stat_r, res_stat_nxt;
  logic             out_valid_r, out_valid_nxt, out_int_r, out_int_nxt;
  logic             out_stat_r, out_stat_nxt;
  logic             iss_r, iss_nxt, hit0_r, hit0_nxt, hit1_r, hit1_nxt;
  logic             wr0, wr1, full, proj_clear, pend, sep;
  logic [IDX_W-1:0] rd_addr;
  logic signed [AW-1:0] ax_r, ax_nxt, ay_r, ay_nxt, ex, ey;
  cpo_pkg::proj_ctl_t ctl;

  assign wdata = {sat_add(in_vertex_x, in_offset_x), sat_add(in_vertex_y, in_offset_y)};

  always_ff @(posedge clk) begin
    if (wr0) mem0[cnt0_r[IDX_W-1:0]] <= wdata;
    if (wr1) mem1[cnt1_r[IDX_W-1:0]] <= wdata;
    rd0_r <= mem0[rd_addr];
    rd1_r <= mem1[rd_addr];
  end

  assign n_cur = poly_r ? cnt1_r : cnt0_r;
  assign m_cnt = (cnt0_r > cnt1_r) ? cnt0_r : cnt1_r;
  assign e_inc = e_r + CNT_W'(1);
  assign full  = in_mode ? (cnt1_r >= CAP) : (cnt0_r >= CAP);
  assign vj    = poly_r ? rd1_r : rd0_r;
  assign ex    = AW'($signed(vj[2*CW-1:CW])) - AW'($signed(vi_r[2*CW-1:CW]));
  assign ey    = AW'($signed(vj[CW-1:0])) - AW'($signed(vi_r[CW-1:0]));

  always_comb begin
    state_nxt     = state_r;
    cnt0_nxt      = cnt0_r;
    cnt1_nxt      = cnt1_r;
    ovf_nxt       = ovf_r;
    poly_nxt      = poly_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    vi_nxt        = vi_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    res_int_nxt   = res_int_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_int_nxt   = out_int_r;
    out_stat_nxt  = out_stat_r;
    iss_nxt       = 1'b0;
    hit0_nxt      = 1'b0;
    hit1_nxt      = 1'b0;
    wr0           = 1'b0;
    wr1           = 1'b0;
    proj_clear    = 1'b0;
    rd_addr       = k_r[IDX_W-1:0];
    in_stall      = (state_r != cpo_pkg::ST_IDLE);
    unique case (state_r)
      cpo_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else if (in_mode) begin
            wr1      = 1'b1;
            cnt1_nxt = cnt1_r + CNT_W'(1);
          end else begin
            wr0      = 1'b1;
            cnt0_nxt = cnt0_r + CNT_W'(1);
          end
          if (in_last) begin
            if (ovf_r || full) begin
              res_int_nxt  = 1'b0;
              res_stat_nxt = 1'b1;
              state_nxt    = cpo_pkg::ST_RESULT;
            end else begin
              poly_nxt  = 1'b0;
              e_nxt     = '0;
              state_nxt = cpo_pkg::ST_NEXT;
            end
          end
        end
      end
      cpo_pkg::ST_NEXT: begin
        if (e_r < n_cur) begin
          state_nxt = cpo_pkg::ST_EDGE_A;
        end else if (!poly_r) begin
          poly_nxt = 1'b1;
          e_nxt    = '0;
        end else begin
          res_int_nxt  = 1'b1;
          res_stat_nxt = 1'b0;
          state_nxt    = cpo_pkg::ST_RESULT;
        end
      end
      cpo_pkg::ST_EDGE_A: begin
        rd_addr   = e_r[IDX_W-1:0];
        state_nxt = cpo_pkg::ST_EDGE_B;
      end
      cpo_pkg::ST_EDGE_B: begin
        rd_addr   = (e_inc >= n_cur) ? '0 : e_inc[IDX_W-1:0];
        vi_nxt    = vj;
        state_nxt = cpo_pkg::ST_EDGE_C;
      end
      cpo_pkg::ST_EDGE_C: begin
        ax_nxt     = -ey;
        ay_nxt     = ex;
        k_nxt      = '0;
        proj_clear = 1'b1;
        state_nxt  = cpo_pkg::ST_PROJ;
      end
      cpo_pkg::ST_PROJ: begin
        if (k_r < m_cnt) begin
          iss_nxt  = 1'b1;
          hit0_nxt = (k_r < cnt0_r);
          hit1_nxt = (k_r < cnt1_r);
          k_nxt    = k_r + CNT_W'(1);
        end else if (!iss_r && !pend) begin
          state_nxt = cpo_pkg::ST_EVAL;
        end
      end
      cpo_pkg::ST_EVAL: begin
        if (sep) begin
          res_int_nxt  = 1'b0;
          res_stat_nxt = 1'b0;
          state_nxt    = cpo_pkg::ST_RESULT;
        end else begin
          e_nxt     = e_inc;
          state_nxt = cpo_pkg::ST_NEXT;
        end
      end
      cpo_pkg::ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_int_nxt   = res_int_r;
          out_stat_nxt  = res_stat_r;
          cnt0_nxt      = '0;
          cnt1_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = cpo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpo_pkg::ST_IDLE;
      cnt0_r      <= '0;
      cnt1_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= 1'b0;
      hit0_r      <= 1'b0;
      hit1_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt0_r      <= cnt0_nxt;
      cnt1_r      <= cnt1_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      hit0_r      <= hit0_nxt;
      hit1_r      <= hit1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    poly_r     <= poly_nxt;
    e_r        <= e_nxt;
    k_r        <= k_nxt;
    vi_r       <= vi_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    res_int_r  <= res_int_nxt;
    res_stat_r <= res_stat_nxt;
    out_int_r  <= out_int_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign ctl.clear = proj_clear;
  assign ctl.valid = iss_r;
  assign ctl.hit0  = hit0_r;
  assign ctl.hit1  = hit1_r;

  cpo_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .axis_x    (ax_r),
    .axis_y    (ay_r),
    .pt0       (rd0_r),
    .pt1       (rd1_r),
    .pending   (pend),
    .separates (sep)
  );

  assign out_valid      = out_valid_r;
  assign out_intersects = out_int_r;
  assign out_status     = out_stat_r;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } vtx_t;

  typedef struct {
    bit intersects;
    bit status;
  } verdict_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic signed [15:0] in_vertex_x;
  logic signed [15:0] in_vertex_y;
  logic signed [15:0] in_offset_x;
  logic signed [15:0] in_offset_y;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic               out_intersects;
  logic               out_status;

  verdict_t    verdicts_due[$];
  longint      corner_x[2][cpo_pkg::MAX_VERTICES];
  longint      corner_y[2][cpo_pkg::MAX_VERTICES];
  int unsigned corner_count[2];
  bit          capacity_hit;
  vtx_t        shape_a[$];
  vtx_t        shape_b[$];
  int          errors;
  int          accepted_items;
  int          stall_left;
  bit          no_idle;

  convex_polygon_overlap_test uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_offset_x    (in_offset_x),
    .in_offset_y    (in_offset_y),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_intersects (out_intersects),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint clamp_coord(input longint v);
    longint top;
    top = (longint'(1) << (cpo_pkg::COORD_W - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic void project_polygon(input int p, input longint ax, input longint ay,
                                          output longint lo, output longint hi);
    longint d;
    lo = 0;
    hi = 0;
    for (int i = 0; i < int'(corner_count[p]); i++) begin
      d = ax * corner_x[p][i] + ay * corner_y[p][i];
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  function automatic bit axis_separates(input longint ex, input longint ey);
    longint lo0, hi0, lo1, hi1;
    project_polygon(0, -ey, ex, lo0, hi0);
    project_polygon(1, -ey, ex, lo1, hi1);
    if (lo0 < lo1) return hi0 < lo1;
    return hi1 < lo0;
  endfunction

  function automatic bit polygon_separates(input int p);
    int j;
    for (int i = 0; i < int'(corner_count[p]); i++) begin
      j = (i + 1 >= int'(corner_count[p])) ? 0 : i + 1;
      if (axis_separates(corner_x[p][j] - corner_x[p][i], corner_y[p][j] - corner_y[p][i]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void record_vertex(input bit mode, input vtx_t v, input bit last);
    verdict_t due;
    int       p;
    p = int'(mode);
    if (corner_count[p] < cpo_pkg::MAX_VERTICES) begin
      corner_x[p][corner_count[p]] = clamp_coord(longint'(v.vx) + longint'(v.ox));
      corner_y[p][corner_count[p]] = clamp_coord(longint'(v.vy) + longint'(v.oy));
      corner_count[p]++;
    end else begin
      capacity_hit = 1'b1;
    end
    if (last) begin
      if (capacity_hit) begin
        due.intersects = 1'b0;
        due.status     = 1'b1;
      end else begin
        due.intersects = !(polygon_separates(0) || polygon_separates(1));
        due.status     = 1'b0;
      end
      verdicts_due.push_back(due);
      corner_count[0] = 0;
      corner_count[1] = 0;
      capacity_hit    = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic vtx_t pt(input int vx, input int vy, input int ox, input int oy);
    vtx_t v;
    v.vx = 16'(vx);
    v.vy = 16'(vy);
    v.ox = 16'(ox);
    v.oy = 16'(oy);
    return v;
  endfunction

  function automatic int dir_x(input int k);
    case (k)
      0: return 8;
      1: return 6;
      2: return 0;
      3: return -6;
      4: return -8;
      5: return -6;
      6: return 0;
      default: return 6;
    endcase
  endfunction

  function automatic int dir_y(input int k);
    return dir_x((k + 6) % 8);
  endfunction

  always @(posedge clk) begin
    verdict_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result with none pending: intersects=%0b status=%0b",
               out_intersects, out_status);
        errors++;
      end else begin
        due = verdicts_due.pop_front();
        if (out_intersects !== due.intersects) begin
          $error("intersects: expected %0b, actual %0b", due.intersects, out_intersects);
          errors++;
        end
        if (out_status !== due.status) begin
          $error("status: expected %0b, actual %0b", due.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_vertex(input bit mode, input vtx_t v, input bit last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_mode     = mode;
    in_vertex_x = v.vx;
    in_vertex_y = v.vy;
    in_offset_x = v.ox;
    in_offset_y = v.oy;
    in_last     = last;
    do @(posedge clk); while (in_stall);
    accepted_items++;
    record_vertex(mode, v, last);
  endtask

  task automatic wait_for_verdicts();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_saturation_and_degenerate_edges();
    send_vertex(1'b0, pt(32767, 32767, 1, 1), 1'b0);
    send_vertex(1'b0, pt(32767, 32767, 32767, 32767), 1'b0);
    send_vertex(1'b0, pt(-32768, -32768, -1, -1), 1'b0);
    send_vertex(1'b1, pt(-32768, -32768, 32767, 32767), 1'b0);
    send_vertex(1'b1, pt(-32768, 32767, -32768, 32767), 1'b1);
  endtask

  task automatic test_touching_segments();
    send_vertex(1'b0, pt(0, 0, 0, 0), 1'b0);
    send_vertex(1'b0, pt(16, 16, 0, 0), 1'b0);
    send_vertex(1'b1, pt(0, 0, 16, 16), 1'b0);
    send_vertex(1'b1, pt(16, -16, 16, 16), 1'b1);
  endtask

  task automatic test_empty_first_polygon();
    send_vertex(1'b1, pt(150, 150, -50, -50), 1'b0);
    send_vertex(1'b1, pt(250, 150, -50, -50), 1'b0);
    send_vertex(1'b1, pt(150, 250, -50, -50), 1'b1);
  endtask

  task automatic test_capacity_overflow();
    for (int i = 0; i < cpo_pkg::MAX_VERTICES; i++)
      send_vertex(1'b0, pt(dir_x(i % 8) * 10, dir_y(i % 8) * 10, 0, 0), 1'b0);
    send_vertex(1'b0, pt(5, 5, 0, 0), 1'b1);
    wait_for_verdicts();
  endtask

  task automatic fill_polygon(input bit p, input int cx, input int cy);
    int   style;
    int   radius;
    int   mask;
    int   n;
    vtx_t v;
    style  = $urandom_range(0, 39);
    radius = $urandom_range(20, 150);
    mask   = $urandom_range(1, 255);
    n      = 0;
    if (style < 2) begin
      radius = $urandom_range(2000, 4095);
      cx     = int'($urandom_range(0, 65535)) - 32768;
      cy     = int'($urandom_range(0, 65535)) - 32768;
    end else if (style == 2) begin
      mask = 0;
    end else if (style == 3) begin
      mask = 0;
      n    = $urandom_range(cpo_pkg::MAX_VERTICES + 1, cpo_pkg::MAX_VERTICES + 4);
    end
    v.ox = 16'(cx);
    v.oy = 16'(cy);
    for (int i = 0; i < n + 8; i++) begin
      if ((i < n) || (i >= n && mask[i - n])) begin
        v.vx = 16'(dir_x(i % 8) * radius);
        v.vy = 16'(dir_y(i % 8) * radius);
        if (p) shape_b.push_back(v);
        else shape_a.push_back(v);
      end
    end
  endtask

  task automatic test_random_shapes(input int quota);
    int   stop_at;
    int   cx;
    int   cy;
    bit   side;
    bit   last;
    vtx_t v;
    stop_at = accepted_items + quota;
    while (accepted_items < stop_at) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) wait_for_verdicts();
      cx = int'($urandom_range(0, 16000)) - 8000;
      cy = int'($urandom_range(0, 16000)) - 8000;
      fill_polygon(1'b0, cx, cy);
      fill_polygon(1'b1, cx + int'($urandom_range(0, 4000)) - 2000,
                   cy + int'($urandom_range(0, 4000)) - 2000);
      if (shape_a.size() + shape_b.size() == 0) shape_a.push_back(pt(0, 0, cx, cy));
      while (shape_a.size() + shape_b.size() != 0) begin
        if (shape_a.size() == 0) side = 1'b1;
        else if (shape_b.size() == 0) side = 1'b0;
        else side = 1'($urandom_range(0, 1));
        v    = side ? shape_b.pop_front() : shape_a.pop_front();
        last = (shape_a.size() + shape_b.size() == 0);
        send_vertex(side, v, last);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_noise(input int quota);
    int   stop_at;
    vtx_t v;
    stop_at = accepted_items + quota;
    while (accepted_items < stop_at) begin
      v.vx = 16'($urandom);
      v.vy = 16'($urandom);
      v.ox = 16'($urandom);
      v.oy = 16'($urandom);
      send_vertex(1'($urandom_range(0, 1)), v, ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    errors          = 0;
    accepted_items  = 0;
    no_idle         = 1'b0;
    capacity_hit    = 1'b0;
    corner_count[0] = 0;
    corner_count[1] = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = 1'b0;
    in_vertex_x     = '0;
    in_vertex_y     = '0;
    in_offset_x     = '0;
    in_offset_y     = '0;
    in_last         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_saturation_and_degenerate_edges();
    test_touching_segments();
    test_empty_first_polygon();
    test_capacity_overflow();
    test_random_shapes(680);
    test_random_noise(100);

    wait_for_verdicts();
    repeat (50) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: convex_polygon_overlap_test.f
sv/cpo_pkg.sv
sv/cpo_proj.sv
sv/convex_polygon_overlap_test.sv
dv/testbench.sv
